// ===== sv/tps_pkg.sv =====
// Shared types and constants for the triangle plane slice block.
package tps_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned MAG_WIDTH   = COORD_WIDTH + 1;
  localparam int unsigned PROD_WIDTH  = 2 * MAG_WIDTH;
  // one multiply stage plus one divide stage per quotient bit
  localparam int unsigned LANE_LAT    = MAG_WIDTH + 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [MAG_WIDTH-1:0]          mag_t;

  typedef struct packed {
    coord_t plane_z;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } in_item_t;

  typedef struct packed {
    logic [1:0] point_count;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     second_x;
    coord_t     second_y;
  } out_item_t;

  // one output point: a vertex passed through, or an edge to interpolate
  typedef struct packed {
    logic   is_edge;
    coord_t base_x;
    coord_t base_y;
    mag_t   dp_x;
    mag_t   dp_y;
    logic   neg_x;
    logic   neg_y;
    mag_t   num;
    mag_t   den;
  } slot_t;

  typedef struct packed {
    logic [1:0] point_count;
    slot_t      s0;
    slot_t      s1;
  } work_t;

  // per-point data kept alongside the divider pipeline
  typedef struct packed {
    logic   is_edge;
    coord_t base_x;
    coord_t base_y;
    logic   neg_x;
    logic   neg_y;
  } side_slot_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] point_count;
    side_slot_t s0;
    side_slot_t s1;
  } side_t;

  // magnitude of a - b
  function automatic mag_t abs_diff(coord_t a, coord_t b);
    logic [MAG_WIDTH-1:0] d;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    return d[MAG_WIDTH-1] ? (~d + 1'b1) : d;
  endfunction

endpackage

// ===== sv/tps_front.sv =====
// Front end: classifies vertices and edges against the plane and picks up to two points.
module tps_front (
  input  tps_pkg::in_item_t item_i,
  output tps_pkg::work_t    work_o
);

  tps_pkg::coord_t vx [3];
  tps_pkg::coord_t vy [3];
  tps_pkg::coord_t vz [3];
  tps_pkg::slot_t  cand [6];
  logic [5:0]      hit;
  logic [1:0]      n;
  tps_pkg::slot_t  s0, s1;

  localparam int E0 [3] = '{0, 1, 0};
  localparam int E1 [3] = '{1, 2, 2};

  assign vx[0] = item_i.ax;
  assign vy[0] = item_i.ay;
  assign vz[0] = item_i.az;
  assign vx[1] = item_i.bx;
  assign vy[1] = item_i.by;
  assign vz[1] = item_i.bz;
  assign vx[2] = item_i.cx;
  assign vy[2] = item_i.cy;
  assign vz[2] = item_i.cz;

  // candidates: three vertices on the plane, then three straddling edges
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hit[i]          = (vz[i] == item_i.plane_z);
      cand[i]         = '0;
      cand[i].base_x  = vx[i];
      cand[i].base_y  = vy[i];
    end
    for (int e = 0; e < 3; e++) begin
      hit[3+e] = ((vz[E0[e]] > item_i.plane_z) && (vz[E1[e]] < item_i.plane_z)) ||
                 ((vz[E0[e]] < item_i.plane_z) && (vz[E1[e]] > item_i.plane_z));
      cand[3+e].is_edge = 1'b1;
      cand[3+e].base_x  = vx[E0[e]];
      cand[3+e].base_y  = vy[E0[e]];
      cand[3+e].dp_x    = tps_pkg::abs_diff(vx[E1[e]], vx[E0[e]]);
      cand[3+e].dp_y    = tps_pkg::abs_diff(vy[E1[e]], vy[E0[e]]);
      cand[3+e].neg_x   = vx[E1[e]] < vx[E0[e]];
      cand[3+e].neg_y   = vy[E1[e]] < vy[E0[e]];
      cand[3+e].num     = tps_pkg::abs_diff(item_i.plane_z, vz[E0[e]]);
      cand[3+e].den     = tps_pkg::abs_diff(vz[E1[e]], vz[E0[e]]);
    end
  end

  // take the first two hits in priority order; unused slots stay zero
  always_comb begin
    n  = 2'd0;
    s0 = '0;
    s1 = '0;
    for (int k = 0; k < 6; k++) begin
      if (hit[k] && n == 2'd0) begin
        s0 = cand[k];
        n  = 2'd1;
      end else if (hit[k] && n == 2'd1) begin
        s1 = cand[k];
        n  = 2'd2;
      end
    end
  end

  assign work_o.point_count = n;
  assign work_o.s0          = s0;
  assign work_o.s1          = s1;

endmodule

// ===== sv/tps_queue.sv =====
// Two-entry queue between the classify front end and the interpolation back end.
module tps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tps_pkg::work_t  push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output tps_pkg::work_t  head_o
);

  localparam int unsigned PW = $clog2(tps_pkg::QUEUE_DEPTH);

  tps_pkg::work_t          mem_q [tps_pkg::QUEUE_DEPTH];
  logic [PW-1:0]           wr_q, rd_q;
  logic [PW:0]             cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(tps_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

// ===== sv/tps_lane.sv =====
// One coordinate lane: dp * num / den, a multiply stage then one quotient bit per stage.
module tps_lane (
  input  logic          clk_i,
  input  logic          en_i,
  input  tps_pkg::mag_t dp_i,
  input  tps_pkg::mag_t num_i,
  input  tps_pkg::mag_t den_i,
  output tps_pkg::mag_t quot_o
);

  localparam int unsigned MW = tps_pkg::MAG_WIDTH;

  logic [2*MW-1:0] prod;
  logic [MW-1:0]   r_q   [MW+1];
  logic [MW-1:0]   lo_q  [MW+1];
  logic [MW-1:0]   q_q   [MW+1];
  logic [MW-1:0]   den_q [MW+1];
  logic [MW-1:0]   r_d   [MW];
  logic            qb_d  [MW];
  logic [MW:0]     trial [MW];

  assign prod = dp_i * num_i;

  // restoring step: shift in the next product bit, subtract if it fits
  always_comb begin
    for (int k = 0; k < MW; k++) begin
      trial[k] = {r_q[k], lo_q[k][MW-1]};
      qb_d[k]  = trial[k] >= {1'b0, den_q[k]};
      r_d[k]   = qb_d[k] ? MW'(trial[k] - {1'b0, den_q[k]}) : trial[k][MW-1:0];
    end
  end

  // quotient fits MW bits, so the top half already stands below den
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= prod[2*MW-1:MW];
      lo_q[0]  <= prod[MW-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den_i;
      for (int k = 0; k < MW; k++) begin
        r_q[k+1]   <= r_d[k];
        lo_q[k+1]  <= {lo_q[k][MW-2:0], 1'b0};
        q_q[k+1]   <= {q_q[k][MW-2:0], qb_d[k]};
        den_q[k+1] <= den_q[k];
      end
    end
  end

  assign quot_o = q_q[MW];

endmodule

// ===== sv/tps_back.sv =====
// Back end: four interpolation lanes, side data pipeline and the output register.
module tps_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  tps_pkg::work_t    head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tps_pkg::out_item_t out_item_o
);

  localparam int unsigned LAT = tps_pkg::LANE_LAT;
  localparam int unsigned CW  = tps_pkg::COORD_WIDTH;

  logic               adv;
  logic               out_valid_q;
  tps_pkg::out_item_t out_q;
  tps_pkg::side_t     side_q [LAT];
  tps_pkg::side_t     side_in;
  tps_pkg::mag_t      q0x, q0y, q1x, q1y;

  // whole pipeline moves when the output register can take an item
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && head_valid_i;

  always_comb begin
    side_in             = '0;
    side_in.valid       = head_valid_i;
    side_in.point_count = head_i.point_count;
    side_in.s0.is_edge  = head_i.s0.is_edge;
    side_in.s0.base_x   = head_i.s0.base_x;
    side_in.s0.base_y   = head_i.s0.base_y;
    side_in.s0.neg_x    = head_i.s0.neg_x;
    side_in.s0.neg_y    = head_i.s0.neg_y;
    side_in.s1.is_edge  = head_i.s1.is_edge;
    side_in.s1.base_x   = head_i.s1.base_x;
    side_in.s1.base_y   = head_i.s1.base_y;
    side_in.s1.neg_x    = head_i.s1.neg_x;
    side_in.s1.neg_y    = head_i.s1.neg_y;
  end

  tps_lane u_lane_0x (.clk_i, .en_i(adv), .dp_i(head_i.s0.dp_x), .num_i(head_i.s0.num),
                      .den_i(head_i.s0.den), .quot_o(q0x));
  tps_lane u_lane_0y (.clk_i, .en_i(adv), .dp_i(head_i.s0.dp_y), .num_i(head_i.s0.num),
                      .den_i(head_i.s0.den), .quot_o(q0y));
  tps_lane u_lane_1x (.clk_i, .en_i(adv), .dp_i(head_i.s1.dp_x), .num_i(head_i.s1.num),
                      .den_i(head_i.s1.den), .quot_o(q1x));
  tps_lane u_lane_1y (.clk_i, .en_i(adv), .dp_i(head_i.s1.dp_y), .num_i(head_i.s1.num),
                      .den_i(head_i.s1.den), .quot_o(q1y));

  // side data travels in step with the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) side_q[k] <= '0;
    end else if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  function automatic tps_pkg::coord_t finish(logic is_edge, logic neg,
                                             tps_pkg::coord_t base, tps_pkg::mag_t q);
    logic [CW-1:0] b;
    b = base;
    if (!is_edge) return base;
    return neg ? (b - q[CW-1:0]) : (b + q[CW-1:0]);
  endfunction

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= side_q[LAT-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.point_count <= side_q[LAT-1].point_count;
      out_q.first_x  <= finish(side_q[LAT-1].s0.is_edge, side_q[LAT-1].s0.neg_x,
                               side_q[LAT-1].s0.base_x, q0x);
      out_q.first_y  <= finish(side_q[LAT-1].s0.is_edge, side_q[LAT-1].s0.neg_y,
                               side_q[LAT-1].s0.base_y, q0y);
      out_q.second_x <= finish(side_q[LAT-1].s1.is_edge, side_q[LAT-1].s1.neg_x,
                               side_q[LAT-1].s1.base_x, q1x);
      out_q.second_y <= finish(side_q[LAT-1].s1.is_edge, side_q[LAT-1].s1.neg_y,
                               side_q[LAT-1].s1.base_y, q1y);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== sv/triangle_plane_slice.sv =====
// Top level of the triangle plane slice block.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid_i/in_stall_o | in_item_i  (plane, a, b, c)
//  out     | output    | out_valid_o/out_stall_i | out_item_o (count, 2 points)
//
// One triangle per cycle sustained while out_stall_i does not hold the back end.
// From accept to result an item passes the queue write at the accept edge, then
// one multiply stage and 33 quotient-bit stages in each of the four lanes, and
// then the output register.
// Reset clears the queue, stage valid bits and the output valid; no clearing pass.
// An output stall freezes the back end; the front keeps accepting until the
// two-entry queue fills.
module triangle_plane_slice (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tps_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tps_pkg::out_item_t  out_item_o
);

  tps_pkg::work_t work, head;
  logic           full, empty, pop, push;

  tps_front u_front (.item_i(in_item_i), .work_o(work));

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  tps_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(work),
    .pop_i(pop), .full_o(full), .empty_o(empty), .head_o(head)
  );

  tps_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i(!empty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

// ===== sv/tps_checker.sv =====
// Port-level checks for the triangle plane slice block, with its bind.
module tps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tps_pkg::out_item_t out_item_o
);

  // held result does not change while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.point_count != 2'd3)
    else $error("point count out of range");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.point_count != 2'd2 |->
      out_item_o.second_x == '0 && out_item_o.second_y == '0)
    else $error("unused second point not zero");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.point_count == 2'd0 |->
      out_item_o.first_x == '0 && out_item_o.first_y == '0)
    else $error("unused first point not zero");

endmodule

bind triangle_plane_slice tps_checker u_tps_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .out_item_o(out_item_o)
);
